[rtl/rrlrq_pkg.sv]
// Shared constants, types and helpers for the ready queue.
`timescale 1ns / 1ps
`default_nettype none

package rrlrq_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int WEIGHT_MAX  = 100;

    localparam int ID_W     = 7;
    localparam int WGT_W    = 7;
    localparam int TICKET_W = 14;
    localparam int STATUS_W = 2;
    localparam int QCOUNT_W = 8;
    localparam int TOTAL_W  = 14;

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = $clog2(QUEUE_DEPTH * WEIGHT_MAX + 1);
    localparam int CMP_W   = (SUM_W > TICKET_W) ? SUM_W : TICKET_W;
    localparam int ENTRY_W = ID_W + WGT_W;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    localparam logic MODE_RR      = 1'b0;
    localparam logic MODE_LOTTERY = 1'b1;

    localparam logic REG_MODE = 1'b0;

    localparam int FULL_COUNT_SAT = (QUEUE_DEPTH > 255) ? 255 : QUEUE_DEPTH;

    typedef struct packed {
        logic clear;
        logic acc;
    } scan_ctrl_t;

    function automatic logic [QCOUNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        if (32'(c) > 32'hFF) begin
            return 8'hFF;
        end
        return QCOUNT_W'(c);
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_total(input logic [SUM_W-1:0] s);
        if (32'(s) > 32'h3FFF) begin
            return 14'h3FFF;
        end
        return TOTAL_W'(s);
    endfunction

endpackage

`default_nettype wire

[rtl/round_robin_lottery_ready_queue.sv]
// Ready queue top level: sequencer, entry RAM, scan unit and config port.
//
// Usage: words enter on req_valid/req_stall and one result word per request
// leaves on rsp_valid/rsp_stall. A word is taken at a clock edge with valid
// high and stall low. req_stall is high while a request is being worked.
// The APB port holds scheduling_mode at byte address 0 (pready always high).
//
// Sequence: an enqueue or a refused request goes straight to the finish
// state, which loads its result. A dequeue walks the entries from the head
// through the single RAM read port, reading and then checking each one up
// to the pick, closes the gap by reading and writing back each later entry
// and then loads its result in the finish state. One request is in flight
// at a time; the next may be taken in the cycle after the result is loaded.
//
// The result sits in an output register; while rsp_stall is high it holds
// and the sequencer waits to load the next result, but a new request is
// still taken when the sequencer is idle.
// Reset empties the queue, clears the weight total and selects round robin;
// the entry RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_lottery_ready_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rrlrq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [rrlrq_pkg::PDATA_W-1:0]  pwdata,
    output logic      [rrlrq_pkg::PDATA_W-1:0]  prdata,
    output logic                                pready,
    input  wire logic                           req_valid,
    output logic                                req_stall,
    input  wire logic                           action,
    input  wire logic [rrlrq_pkg::ID_W-1:0]     thread_id,
    input  wire logic [rrlrq_pkg::WGT_W-1:0]    weight,
    input  wire logic [rrlrq_pkg::TICKET_W-1:0] ticket,
    output logic                                rsp_valid,
    input  wire logic                           rsp_stall,
    output logic      [rrlrq_pkg::ID_W-1:0]     picked_id,
    output logic      [rrlrq_pkg::WGT_W-1:0]    picked_weight,
    output logic      [rrlrq_pkg::STATUS_W-1:0] status,
    output logic      [rrlrq_pkg::QCOUNT_W-1:0] queue_count,
    output logic      [rrlrq_pkg::TOTAL_W-1:0]  weight_total
);
    import rrlrq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic                  mode_reg, mode_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [TICKET_W-1:0]   ticket_reg, ticket_next;
    logic [ID_W-1:0]       pid_reg, pid_next;
    logic [WGT_W-1:0]      pw_reg, pw_next;
    logic [STATUS_W-1:0]   stat_reg, stat_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [ID_W-1:0]       rsp_id_reg, rsp_id_next;
    logic [WGT_W-1:0]      rsp_w_reg, rsp_w_next;
    logic [STATUS_W-1:0]   rsp_stat_reg, rsp_stat_next;
    logic [QCOUNT_W-1:0]   rsp_cnt_reg, rsp_cnt_next;
    logic [TOTAL_W-1:0]    rsp_tot_reg, rsp_tot_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    scan_ctrl_t            scan_ctrl;
    logic                  scan_hit;

    logic [ID_W-1:0]       rd_id;
    logic [WGT_W-1:0]      rd_w;
    logic [WGT_W-1:0]      wsat;
    logic                  req_take;
    logic                  full;
    logic                  pick_now;
    logic [CNT_W-1:0]      idx_ext;
    logic                  cfg_write;

    assign rd_id    = ram_rdata[ENTRY_W-1:WGT_W];
    assign rd_w     = ram_rdata[WGT_W-1:0];
    assign wsat     = ({1'b0, weight} > 8'(WEIGHT_MAX)) ? WGT_W'(WEIGHT_MAX) : weight;
    assign req_take = req_valid && (state_reg == S_IDLE);
    assign full     = count_reg >= CNT_W'(QUEUE_DEPTH);
    assign idx_ext  = CNT_W'(idx_reg);
    assign pick_now = (mode_reg == MODE_RR) || scan_hit || (idx_ext + 1'b1 == count_reg);

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_MODE) ? PDATA_W'(mode_reg) : '0;

    assign req_stall     = state_reg != S_IDLE;
    assign rsp_valid     = rsp_valid_reg;
    assign picked_id     = rsp_id_reg;
    assign picked_weight = rsp_w_reg;
    assign status        = rsp_stat_reg;
    assign queue_count   = rsp_cnt_reg;
    assign weight_total  = rsp_tot_reg;

    rrlrq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rrlrq_scan_unit u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scan_ctrl),
        .weight (rd_w),
        .ticket (ticket_reg),
        .hit    (scan_hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        ticket_next    = ticket_reg;
        pid_next       = pid_reg;
        pw_next        = pw_reg;
        stat_next      = stat_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_id_next    = rsp_id_reg;
        rsp_w_next     = rsp_w_reg;
        rsp_stat_next  = rsp_stat_reg;
        rsp_cnt_next   = rsp_cnt_reg;
        rsp_tot_next   = rsp_tot_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = idx_reg;
        scan_ctrl      = '{clear: 1'b0, acc: 1'b0};

        if (cfg_write && (paddr[2] == REG_MODE))
        begin
            mode_next = pwdata[0];
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    pid_next    = '0;
                    pw_next     = '0;
                    ticket_next = ticket;
                    idx_next    = '0;
                    state_next  = S_FINISH;
                    if (action == ACT_ENQUEUE)
                    begin
                        if (full)
                        begin
                            stat_next = STATUS_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[IDX_W-1:0];
                            ram_wdata  = {thread_id, wsat};
                            count_next = count_reg + 1'b1;
                            sum_next   = sum_reg + SUM_W'(wsat);
                            stat_next  = STATUS_OK;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        stat_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        stat_next       = STATUS_OK;
                        scan_ctrl.clear = 1'b1;
                        state_next      = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                scan_ctrl.acc = 1'b1;
                if (pick_now)
                begin
                    pid_next   = rd_id;
                    pw_next    = rd_w;
                    count_next = count_reg - 1'b1;
                    sum_next   = (sum_reg >= SUM_W'(rd_w)) ? sum_reg - SUM_W'(rd_w) : '0;
                    state_next = (idx_ext < count_reg - 1'b1) ? S_SHIFT_RD : S_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                ram_raddr  = idx_reg + 1'b1;
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_ext + 1'b1 < count_reg) ? S_SHIFT_RD : S_FINISH;
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_id_next    = pid_reg;
                    rsp_w_next     = pw_reg;
                    rsp_stat_next  = stat_reg;
                    rsp_cnt_next   = sat_count(count_reg);
                    rsp_tot_next   = sat_total(sum_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_RR;
            count_reg     <= '0;
            sum_reg       <= '0;
            idx_reg       <= '0;
            ticket_reg    <= '0;
            pid_reg       <= '0;
            pw_reg        <= '0;
            stat_reg      <= STATUS_OK;
            rsp_valid_reg <= 1'b0;
            rsp_id_reg    <= '0;
            rsp_w_reg     <= '0;
            rsp_stat_reg  <= STATUS_OK;
            rsp_cnt_reg   <= '0;
            rsp_tot_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            idx_reg       <= idx_next;
            ticket_reg    <= ticket_next;
            pid_reg       <= pid_next;
            pw_reg        <= pw_next;
            stat_reg      <= stat_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_id_reg    <= rsp_id_next;
            rsp_w_reg     <= rsp_w_next;
            rsp_stat_reg  <= rsp_stat_next;
            rsp_cnt_reg   <= rsp_cnt_next;
            rsp_tot_reg   <= rsp_tot_next;
        end
    end

endmodule

`default_nettype wire

[rtl/rrlrq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rrlrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/rrlrq_scan_unit.sv]
// Running-weight accumulator and ticket compare shared by every scan step.
`timescale 1ns / 1ps
`default_nettype none

module rrlrq_scan_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire rrlrq_pkg::scan_ctrl_t          ctrl,
    input  wire logic [rrlrq_pkg::WGT_W-1:0]    weight,
    input  wire logic [rrlrq_pkg::TICKET_W-1:0] ticket,
    output logic                                hit
);
    import rrlrq_pkg::*;

    logic [SUM_W-1:0] run_reg;
    logic [SUM_W-1:0] run_next;
    logic [SUM_W-1:0] run_sum;

    assign run_sum = run_reg + SUM_W'(weight);
    assign hit     = CMP_W'(ticket) <= CMP_W'(run_sum);

    always_comb
    begin
        run_next = run_reg;
        if (ctrl.clear)
        begin
            run_next = '0;
        end
        else if (ctrl.acc)
        begin
            run_next = run_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

endmodule

`default_nettype wire

[rtl/rrlrq_checker.sv]
// Port-level checks for the ready queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rrlrq_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rrlrq_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [rrlrq_pkg::PDATA_W-1:0]  pwdata,
    input  wire logic [rrlrq_pkg::PDATA_W-1:0]  prdata,
    input  wire logic                           pready,
    input  wire logic                           req_valid,
    input  wire logic                           req_stall,
    input  wire logic                           action,
    input  wire logic [rrlrq_pkg::ID_W-1:0]     thread_id,
    input  wire logic [rrlrq_pkg::WGT_W-1:0]    weight,
    input  wire logic [rrlrq_pkg::TICKET_W-1:0] ticket,
    input  wire logic                           rsp_valid,
    input  wire logic                           rsp_stall,
    input  wire logic [rrlrq_pkg::ID_W-1:0]     picked_id,
    input  wire logic [rrlrq_pkg::WGT_W-1:0]    picked_weight,
    input  wire logic [rrlrq_pkg::STATUS_W-1:0] status,
    input  wire logic [rrlrq_pkg::QCOUNT_W-1:0] queue_count,
    input  wire logic [rrlrq_pkg::TOTAL_W-1:0]  weight_total
);
    import rrlrq_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(picked_id)
            && $stable(status) && $stable(queue_count) && $stable(weight_total))
        else $error("stalled result word changed");

    a_empty_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STATUS_EMPTY) |-> (queue_count == '0) && (weight_total == '0))
        else $error("empty status with nonzero count or total");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STATUS_FULL) |-> queue_count == QCOUNT_W'(FULL_COUNT_SAT))
        else $error("full status with queue not full");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != STATUS_OK) |-> (picked_id == '0) && (picked_weight == '0))
        else $error("refused request returned an entry");

    a_no_total_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (queue_count == '0) |-> weight_total == '0)
        else $error("weight total left in an empty queue");

endmodule

bind round_robin_lottery_ready_queue rrlrq_checker u_rrlrq_checker (.*);

`default_nettype wire

[tb/sv/tb_round_robin_lottery_ready_queue.sv]
// Self-checking testbench for the round-robin / lottery ready queue.
`timescale 1ns / 1ps

module tb_round_robin_lottery_ready_queue;

    import rrlrq_pkg::*;

    localparam int HOLD_LEN    = 400;
    localparam int STUCK_LIMIT = 6000;
    localparam int TAIL_WAIT   = 300;
    localparam int SEG_WORDS   = 150;
    localparam int NUM_SEGS    = 6;
    localparam logic [PADDR_W-1:0] MODE_ADDR = PADDR_W'(4 * int'(REG_MODE));

    typedef struct packed {
        logic                action;
        logic [ID_W-1:0]     thread_id;
        logic [WGT_W-1:0]    weight;
        logic [TICKET_W-1:0] ticket;
    } sched_word_t;

    typedef struct packed {
        logic [ID_W-1:0]     tid;
        logic [WGT_W-1:0]    wgt;
        logic [STATUS_W-1:0] status;
        logic [QCOUNT_W-1:0] count;
        logic [TOTAL_W-1:0]  total;
    } sched_result_t;

    typedef struct packed {
        logic [ID_W-1:0]  tid;
        logic [WGT_W-1:0] wgt;
    } ready_entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic                req_valid = 1'b0;
    logic                req_stall;
    logic                action = 1'b0;
    logic [ID_W-1:0]     thread_id = '0;
    logic [WGT_W-1:0]    weight = '0;
    logic [TICKET_W-1:0] ticket = '0;

    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [ID_W-1:0]     picked_id;
    logic [WGT_W-1:0]    picked_weight;
    logic [STATUS_W-1:0] status;
    logic [QCOUNT_W-1:0] queue_count;
    logic [TOTAL_W-1:0]  weight_total;

    round_robin_lottery_ready_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .action        (action),
        .thread_id     (thread_id),
        .weight        (weight),
        .ticket        (ticket),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .picked_id     (picked_id),
        .picked_weight (picked_weight),
        .status        (status),
        .queue_count   (queue_count),
        .weight_total  (weight_total)
    );

    always #6 clk = ~clk;

    ready_entry_t  ready_q[$];
    int unsigned   total_weight = 0;
    logic          sched_mode = MODE_RR;

    sched_word_t   pending_q[$];
    sched_result_t expected_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stuck_cycles = 0;

    int fail_count = 0;
    int words_taken = 0;
    int results_seen = 0;
    int lottery_picks = 0;
    int full_refusals = 0;
    int empty_refusals = 0;
    int mode_writes = 0;

    function automatic sched_result_t schedule_word(input sched_word_t w);
        sched_result_t r;
        int unsigned   wt;
        int unsigned   run;
        int            pick;
        bit            found;
        r = '0;
        if (w.action == ACT_ENQUEUE)
        begin
            if (ready_q.size() >= QUEUE_DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                wt = (w.weight > WEIGHT_MAX) ? WEIGHT_MAX : w.weight;
                ready_q.push_back('{tid: w.thread_id, wgt: WGT_W'(wt)});
                total_weight += wt;
                r.status = STATUS_OK;
            end
        end
        else if (ready_q.size() == 0)
        begin
            r.status = STATUS_EMPTY;
        end
        else
        begin
            pick = 0;
            if (sched_mode == MODE_LOTTERY)
            begin
                lottery_picks++;
                pick = ready_q.size() - 1;
                run = 0;
                found = 1'b0;
                for (int i = 0; i < ready_q.size(); i++)
                begin
                    if (!found)
                    begin
                        run += ready_q[i].wgt;
                        if (w.ticket <= run)
                        begin
                            pick = i;
                            found = 1'b1;
                        end
                    end
                end
            end
            r.tid = ready_q[pick].tid;
            r.wgt = ready_q[pick].wgt;
            ready_q.delete(pick);
            total_weight = (total_weight >= r.wgt) ? total_weight - r.wgt : 0;
            r.status = STATUS_OK;
        end
        r.count = (ready_q.size() > 255) ? 8'hFF : QCOUNT_W'(ready_q.size());
        r.total = (total_weight > (1 << TOTAL_W) - 1) ? {TOTAL_W{1'b1}}
                                                      : TOTAL_W'(total_weight);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Driver: hold the word until taken, then advance or idle.
    always @(posedge clk)
    begin : drive_req
        sched_word_t nxt;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                expected_q.push_back(schedule_word({action, thread_id, weight, ticket}));
                words_taken++;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_q.pop_front();
                    req_valid <= 1'b1;
                    action    <= nxt.action;
                    thread_id <= nxt.thread_id;
                    weight    <= nxt.weight;
                    ticket    <= nxt.ticket;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_LEN - 1;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_rsp
        sched_result_t want;
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result word with no request outstanding");
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.status == STATUS_FULL) full_refusals++;
                if (want.status == STATUS_EMPTY) empty_refusals++;
                if (picked_id !== want.tid)
                    report_mismatch($sformatf("picked_id %0d, want %0d", picked_id, want.tid));
                if (picked_weight !== want.wgt)
                    report_mismatch($sformatf("picked_weight %0d, want %0d",
                                              picked_weight, want.wgt));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, want.status));
                if (queue_count !== want.count)
                    report_mismatch($sformatf("queue_count %0d, want %0d",
                                              queue_count, want.count));
                if (weight_total !== want.total)
                    report_mismatch($sformatf("weight_total %0d, want %0d",
                                              weight_total, want.total));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Watchdog: no word moved for %0d cycles", STUCK_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic queue_word(input logic act, input int tid, input int wgt, input int tkt);
        sched_word_t w;
        while (pending_q.size() > 6) @(negedge clk);
        w.action    = act;
        w.thread_id = ID_W'(tid);
        w.weight    = WGT_W'(wgt);
        w.ticket    = TICKET_W'(tkt);
        pending_q.push_back(w);
    endtask

    function automatic int pick_weight();
        int r;
        r = $urandom_range(99);
        if (r < 10) return $urandom_range(127, WEIGHT_MAX + 1);
        if (r < 15) return 0;
        if (r < 20) return WEIGHT_MAX;
        return $urandom_range(WEIGHT_MAX, 1);
    endfunction

    function automatic int pick_ticket();
        int r;
        int top;
        r = $urandom_range(99);
        top = (total_weight > 0) ? total_weight : 1;
        if (r < 8) return 0;
        if (r < 18) return $urandom_range((1 << TICKET_W) - 1, 0);
        if (r < 26) return total_weight + $urandom_range(50, 1);
        return $urandom_range(top, 1);
    endfunction

    task automatic queue_random(input logic act);
        queue_word(act, $urandom_range(127), pick_weight(), pick_ticket());
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_q.size() != 0 || req_valid || expected_q.size() != 0);
    endtask

    task automatic write_mode(input logic m);
        wait_drained();
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= {31'($urandom()), m};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk);
        while (!pready);
        sched_mode = m;
        mode_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_segment(input int n, input bit do_fill, input bit do_hold);
        int made;
        int kind;
        int len;
        bit paused;
        made = 0;
        paused = 1'b0;
        if (do_fill)
        begin
            wait_drained();
            len = QUEUE_DEPTH - ready_q.size() + $urandom_range(3, 1);
            repeat (len) queue_random(ACT_ENQUEUE);
            made += len;
        end
        if (do_hold)
        begin
            hold_seq++;
            repeat (20) queue_random(ACT_ENQUEUE);
            made += 20;
        end
        while (made < n)
        begin
            if (!paused && made >= n / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            kind = $urandom_range(99);
            len = $urandom_range(10, 1);
            if (kind < 35)
            begin
                repeat (len) queue_random(ready_q.size() > 30 ? ACT_DEQUEUE : ACT_ENQUEUE);
            end
            else if (kind < 70)
            begin
                repeat (len) queue_random(ACT_DEQUEUE);
            end
            else if (kind < 92)
            begin
                len = $urandom_range(6, 1);
                repeat (len) queue_random(1'($urandom_range(1)));
            end
            else
            begin
                wait_drained();
                len = ready_q.size() + $urandom_range(2, 1);
                repeat (len) queue_random(ACT_DEQUEUE);
            end
            made += len;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_word(ACT_DEQUEUE, 9, 3, 0);
        queue_word(ACT_ENQUEUE, 0, 0, 16383);
        queue_word(ACT_ENQUEUE, 127, WEIGHT_MAX, 0);
        queue_word(ACT_ENQUEUE, 42, 127, 5);
        queue_word(ACT_ENQUEUE, 85, WEIGHT_MAX + 1, 77);
        queue_word(ACT_DEQUEUE, 127, 127, 16383);
        queue_word(ACT_DEQUEUE, 0, 0, 1);

        write_mode(MODE_LOTTERY);
        queue_word(ACT_ENQUEUE, 1, 1, 0);
        queue_word(ACT_ENQUEUE, 2, 30, 0);
        queue_word(ACT_DEQUEUE, 0, 0, 0);
        queue_word(ACT_DEQUEUE, 0, 0, 16383);
        queue_word(ACT_DEQUEUE, 0, 0, 101);
        queue_word(ACT_DEQUEUE, 127, 127, 100);
        queue_word(ACT_DEQUEUE, 0, 0, 16383);
        queue_word(ACT_ENQUEUE, 3, 0, 0);
        queue_word(ACT_ENQUEUE, 4, 0, 0);
        queue_word(ACT_DEQUEUE, 0, 0, 1);
        queue_word(ACT_DEQUEUE, 0, 0, 0);
        queue_word(ACT_ENQUEUE, 126, 99, 8191);
        queue_word(ACT_ENQUEUE, 63, 64, 8192);
        queue_word(ACT_DEQUEUE, 0, 0, 100);
        queue_word(ACT_DEQUEUE, 0, 0, 1);

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            write_mode((seg % 2 == 0) ? MODE_LOTTERY : MODE_RR);
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 50;
                end
                1:
                begin
                    send_idle_pct = 50;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            run_segment(SEG_WORDS, seg == 1 || seg == 4, seg == 0 || seg == 5);
        end
        write_mode(MODE_RR);

        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

        $display("Run covered %0d requests and %0d results, %0d of them lottery picks.",
                 words_taken, results_seen, lottery_picks);
        $display("Refusals seen: %0d on a full queue, %0d on an empty one; %0d mode writes.",
                 full_refusals, empty_refusals, mode_writes);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
